[sv/chs_pkg.sv]
// shared types and constants for the coupon hash set
package chs_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_PROMOTE  = 3'd2;
    localparam logic [2:0] ST_IGNORED  = 3'd3;
    localparam logic [2:0] ST_SLOT     = 3'd4;

    localparam logic [1:0] CFG_LG_SKETCH = 2'd0;
    localparam logic [1:0] CFG_GROW_NUM  = 2'd1;
    localparam logic [1:0] CFG_GROW_DEN  = 2'd2;
    localparam logic [1:0] CFG_START_LG  = 2'd3;

    localparam logic [4:0] LG_SKETCH_RST = 5'd13;
    localparam logic [3:0] GROW_NUM_RST  = 4'd3;
    localparam logic [3:0] GROW_DEN_RST  = 4'd4;
    localparam logic [3:0] START_LG_RST  = 4'd5;

    localparam logic [4:0] LIMIT_OFFSET = 5'd3;
    localparam logic [25:0] KEY_MASK    = 26'h3FFFFFF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_P_RD,
        S_P_CHK,
        S_G_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_PROBE,
        RD_SCAN,
        RD_SLOT
    } rd_src_t;

    typedef enum logic {
        CLR_START,
        CLR_GROW
    } clr_mode_t;

    typedef struct packed {
        logic       in_ready;
        logic       clr_init;
        clr_mode_t  clr_mode;
        logic       clr_step;
        logic       probe_init_ins;
        logic       probe_init_rh;
        logic       probe_step;
        logic       probe_write;
        logic       count_inc;
        logic       scan_init;
        logic       scan_step;
        logic       grow_commit;
        logic       promote_set;
        rd_src_t    rd_src;
        logic       slot_ld;
        logic       out_load;
        logic [2:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] req_type;
        logic       coupon_zero;
        logic       promoted;
        logic       rd_zero;
        logic       rd_match;
        logic       probe_wrap;
        logic       clr_last;
        logic       scan_last;
        logic       grow_need;
        logic       at_limit;
        logic       out_free;
    } stat_t;

endpackage

[sv/chs_ram.sv]
// generic single write port ram with registered read
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/chs_ctrl.sv]
// controller state machine for the coupon hash set
module chs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  chs_pkg::stat_t stat,
    output chs_pkg::cmd_t  cmd
);

    chs_pkg::state_t state_reg, state_next;
    chs_pkg::state_t ret_reg, ret_next;
    logic [2:0]      status_reg, status_next;
    logic            grow_reg, grow_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chs_pkg::S_CLEAR;
            ret_reg    <= chs_pkg::S_IDLE;
            status_reg <= chs_pkg::ST_IGNORED;
            grow_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            status_reg <= status_next;
            grow_reg   <= grow_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.rd_src  = chs_pkg::RD_PROBE;
        cmd.status_code = status_reg;
        state_next  = state_reg;
        ret_next    = ret_reg;
        status_next = status_reg;
        grow_next   = grow_reg;
        case (state_reg)
            chs_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ret_reg;
                end
            end
            chs_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = chs_pkg::S_DISPATCH;
                end
            end
            chs_pkg::S_DISPATCH:
            begin
                case (stat.req_type)
                    chs_pkg::REQ_INSERT:
                    begin
                        if (stat.coupon_zero || stat.promoted)
                        begin
                            status_next = chs_pkg::ST_IGNORED;
                            state_next  = chs_pkg::S_OUT;
                        end
                        else
                        begin
                            cmd.probe_init_ins = 1'b1;
                            state_next = chs_pkg::S_P_RD;
                        end
                    end
                    chs_pkg::REQ_READ:
                    begin
                        state_next = chs_pkg::S_SLOT_RD;
                    end
                    chs_pkg::REQ_CLEAR:
                    begin
                        cmd.clr_init = 1'b1;
                        cmd.clr_mode = chs_pkg::CLR_START;
                        ret_next     = chs_pkg::S_OUT;
                        status_next  = chs_pkg::ST_SLOT;
                        state_next   = chs_pkg::S_CLEAR;
                    end
                    default:
                    begin
                        status_next = chs_pkg::ST_IGNORED;
                        state_next  = chs_pkg::S_OUT;
                    end
                endcase
            end
            chs_pkg::S_P_RD:
            begin
                cmd.rd_src = chs_pkg::RD_PROBE;
                state_next = chs_pkg::S_P_CHK;
            end
            chs_pkg::S_P_CHK:
            begin
                if (!grow_reg)
                begin
                    if (stat.rd_zero)
                    begin
                        cmd.probe_write = 1'b1;
                        cmd.count_inc   = 1'b1;
                        state_next = chs_pkg::S_G_CHK;
                    end
                    else if (stat.rd_match)
                    begin
                        status_next = chs_pkg::ST_DUP;
                        state_next  = chs_pkg::S_OUT;
                    end
                    else if (stat.probe_wrap)
                    begin
                        status_next = chs_pkg::ST_IGNORED;
                        state_next  = chs_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd.probe_step = 1'b1;
                        state_next = chs_pkg::S_P_RD;
                    end
                end
                else if (!stat.rd_zero && !stat.rd_match && !stat.probe_wrap)
                begin
                    cmd.probe_step = 1'b1;
                    state_next = chs_pkg::S_P_RD;
                end
                else
                begin
                    cmd.probe_write = stat.rd_zero;
                    if (stat.scan_last)
                    begin
                        cmd.grow_commit = 1'b1;
                        status_next = chs_pkg::ST_INSERTED;
                        state_next  = chs_pkg::S_OUT;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                        state_next = chs_pkg::S_SCAN_RD;
                    end
                end
            end
            chs_pkg::S_G_CHK:
            begin
                if (stat.grow_need && stat.at_limit)
                begin
                    cmd.promote_set = 1'b1;
                    status_next = chs_pkg::ST_PROMOTE;
                    state_next  = chs_pkg::S_OUT;
                end
                else if (stat.grow_need)
                begin
                    cmd.clr_init  = 1'b1;
                    cmd.clr_mode  = chs_pkg::CLR_GROW;
                    cmd.scan_init = 1'b1;
                    grow_next  = 1'b1;
                    ret_next   = chs_pkg::S_SCAN_RD;
                    state_next = chs_pkg::S_CLEAR;
                end
                else
                begin
                    status_next = chs_pkg::ST_INSERTED;
                    state_next  = chs_pkg::S_OUT;
                end
            end
            chs_pkg::S_SCAN_RD:
            begin
                cmd.rd_src = chs_pkg::RD_SCAN;
                state_next = chs_pkg::S_SCAN_CHK;
            end
            chs_pkg::S_SCAN_CHK:
            begin
                if (!stat.rd_zero)
                begin
                    cmd.probe_init_rh = 1'b1;
                    state_next = chs_pkg::S_P_RD;
                end
                else if (stat.scan_last)
                begin
                    cmd.grow_commit = 1'b1;
                    status_next = chs_pkg::ST_INSERTED;
                    state_next  = chs_pkg::S_OUT;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next = chs_pkg::S_SCAN_RD;
                end
            end
            chs_pkg::S_SLOT_RD:
            begin
                cmd.rd_src = chs_pkg::RD_SLOT;
                state_next = chs_pkg::S_SLOT_CHK;
            end
            chs_pkg::S_SLOT_CHK:
            begin
                cmd.slot_ld = 1'b1;
                status_next = chs_pkg::ST_SLOT;
                state_next  = chs_pkg::S_OUT;
            end
            chs_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    grow_next  = 1'b0;
                    state_next = chs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/chs_dpath.sv]
// datapath: config, table banks, probe unit, counters and output word
module chs_dpath #(
    parameter int MAX_LG_TABLE = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  chs_pkg::cmd_t  cmd,
    output chs_pkg::stat_t stat,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_index,
    input  logic [4:0]     cfg_data,
    input  logic           in_valid,
    input  logic [1:0]     req_type,
    input  logic [31:0]    coupon,
    input  logic [9:0]     slot_index,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     status,
    output logic [31:0]    slot_value,
    output logic [10:0]    coupon_total,
    output logic [3:0]     table_lg_size,
    output logic           promoted
);

    localparam int AW  = MAX_LG_TABLE;
    localparam int LGW = $clog2(MAX_LG_TABLE + 1);
    localparam int CW  = MAX_LG_TABLE + 1;
    localparam int PW  = MAX_LG_TABLE + 5;
    localparam logic [4:0] MAXL = 5'(MAX_LG_TABLE);

    function automatic logic [AW-1:0] lg_mask(input logic [LGW-1:0] lg);
        logic [AW:0] one;
        begin
            one = (AW+1)'(1) << lg;
            lg_mask = AW'(one - (AW+1)'(1));
        end
    endfunction

    logic [4:0]     lgk_reg;
    logic [3:0]     num_reg, den_reg, start_reg;
    logic [1:0]     req_reg;
    logic [31:0]    coupon_reg;
    logic [9:0]     idx_reg;
    logic           active_reg;
    logic [LGW-1:0] cur_reg;
    logic [CW-1:0]  count_reg;
    logic           promote_reg;
    logic [31:0]    key_reg;
    logic [AW-1:0]  p_reg, first_reg, stride_reg;
    logic [LGW-1:0] plg_reg;
    logic           pbank_reg;
    logic [AW-1:0]  scan_reg, clr_cnt_reg;
    logic [LGW-1:0] clr_lg_reg;
    logic           clr_bank_reg, rd_bank_reg;
    logic [31:0]    slot_reg;
    logic           out_valid_reg;
    logic [2:0]     out_status_reg;
    logic [31:0]    out_slot_reg;
    logic [10:0]    out_total_reg;
    logic [3:0]     out_lg_reg;
    logic           out_prom_reg;

    logic [4:0]     start5, lim5, limc;
    logic [LGW-1:0] start_c, cur_inc;
    logic [31:0]    rdata, rdata_a, rdata_b;
    logic [31:0]    pkey;
    logic [LGW-1:0] plg;
    logic           pbank;
    logic [AW-1:0]  pmask, p_next, rd_addr, waddr;
    logic [31:0]    wdata, key26;
    logic           rd_bank, we_a, we_b, accept, in_range;
    logic [PW-1:0]  lhs, rhs;

    assign start5  = {1'b0, start_reg} > MAXL ? MAXL : {1'b0, start_reg};
    assign start_c = LGW'(start5);
    assign lim5    = lgk_reg < chs_pkg::LIMIT_OFFSET ? 5'd0 : lgk_reg - chs_pkg::LIMIT_OFFSET;
    assign limc    = lim5 > MAXL ? MAXL : lim5;
    assign cur_inc = LGW'(cur_reg + LGW'(1));

    assign rdata = rd_bank_reg ? rdata_b : rdata_a;

    assign pkey  = cmd.probe_init_rh ? rdata : coupon_reg;
    assign plg   = cmd.probe_init_rh ? cur_inc : cur_reg;
    assign pbank = cmd.probe_init_rh ? !active_reg : active_reg;
    assign pmask = lg_mask(plg);
    assign key26 = {6'd0, pkey[25:0] & chs_pkg::KEY_MASK};
    assign p_next = (p_reg + stride_reg) & lg_mask(plg_reg);

    assign in_range = (32'(idx_reg) >> cur_reg) == 32'd0;
    assign lhs = PW'(den_reg) * PW'(count_reg);
    assign rhs = PW'(num_reg) << cur_reg;
    assign accept = cmd.in_ready && in_valid;

    always_comb
    begin
        case (cmd.rd_src)
            chs_pkg::RD_PROBE:
            begin
                rd_addr = p_reg;
                rd_bank = pbank_reg;
            end
            chs_pkg::RD_SCAN:
            begin
                rd_addr = scan_reg;
                rd_bank = active_reg;
            end
            chs_pkg::RD_SLOT:
            begin
                rd_addr = AW'(idx_reg);
                rd_bank = active_reg;
            end
            default:
            begin
                rd_addr = p_reg;
                rd_bank = pbank_reg;
            end
        endcase
    end

    assign we_a  = (cmd.clr_step && !clr_bank_reg) || (cmd.probe_write && !pbank_reg);
    assign we_b  = (cmd.clr_step && clr_bank_reg) || (cmd.probe_write && pbank_reg);
    assign waddr = cmd.clr_step ? clr_cnt_reg : p_reg;
    assign wdata = cmd.clr_step ? 32'd0 : key_reg;

    chs_ram #(.WIDTH(32), .DEPTH(1 << MAX_LG_TABLE)) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    chs_ram #(.WIDTH(32), .DEPTH(1 << MAX_LG_TABLE)) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lgk_reg        <= chs_pkg::LG_SKETCH_RST;
            num_reg        <= chs_pkg::GROW_NUM_RST;
            den_reg        <= chs_pkg::GROW_DEN_RST;
            start_reg      <= chs_pkg::START_LG_RST;
            req_reg        <= chs_pkg::REQ_INSERT;
            coupon_reg     <= '0;
            idx_reg        <= '0;
            active_reg     <= 1'b0;
            cur_reg        <= LGW'(chs_pkg::START_LG_RST);
            count_reg      <= '0;
            promote_reg    <= 1'b0;
            key_reg        <= '0;
            p_reg          <= '0;
            first_reg      <= '0;
            stride_reg     <= '0;
            plg_reg        <= '0;
            pbank_reg      <= 1'b0;
            scan_reg       <= '0;
            clr_cnt_reg    <= '0;
            clr_lg_reg     <= LGW'(chs_pkg::START_LG_RST);
            clr_bank_reg   <= 1'b0;
            rd_bank_reg    <= 1'b0;
            slot_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= chs_pkg::ST_IGNORED;
            out_slot_reg   <= '0;
            out_total_reg  <= '0;
            out_lg_reg     <= '0;
            out_prom_reg   <= 1'b0;
        end
        else
        begin
            rd_bank_reg <= rd_bank;
            if (cfg_valid)
            begin
                case (cfg_index)
                    chs_pkg::CFG_LG_SKETCH: lgk_reg   <= cfg_data;
                    chs_pkg::CFG_GROW_NUM:  num_reg   <= cfg_data[3:0];
                    chs_pkg::CFG_GROW_DEN:  den_reg   <= cfg_data[3:0];
                    chs_pkg::CFG_START_LG:  start_reg <= cfg_data[3:0];
                    default:                lgk_reg   <= lgk_reg;
                endcase
            end
            if (accept)
            begin
                req_reg    <= req_type;
                coupon_reg <= coupon;
                idx_reg    <= slot_index;
                slot_reg   <= '0;
            end
            if (cmd.clr_init)
            begin
                clr_cnt_reg <= '0;
                if (cmd.clr_mode == chs_pkg::CLR_START)
                begin
                    clr_bank_reg <= 1'b0;
                    clr_lg_reg   <= start_c;
                    active_reg   <= 1'b0;
                    cur_reg      <= start_c;
                    count_reg    <= '0;
                    promote_reg  <= 1'b0;
                end
                else
                begin
                    clr_bank_reg <= !active_reg;
                    clr_lg_reg   <= cur_inc;
                end
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.probe_init_ins || cmd.probe_init_rh)
            begin
                key_reg    <= pkey;
                p_reg      <= AW'(pkey) & pmask;
                first_reg  <= AW'(pkey) & pmask;
                stride_reg <= AW'(key26 >> plg) | AW'(1);
                plg_reg    <= plg;
                pbank_reg  <= pbank;
            end
            if (cmd.probe_step)
            begin
                p_reg <= p_next;
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_init)
            begin
                scan_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + AW'(1);
            end
            if (cmd.grow_commit)
            begin
                active_reg <= !active_reg;
                cur_reg    <= cur_inc;
            end
            if (cmd.promote_set)
            begin
                promote_reg <= 1'b1;
            end
            if (cmd.slot_ld)
            begin
                slot_reg <= in_range ? rdata : 32'd0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= cmd.status_code;
                out_slot_reg   <= slot_reg;
                out_total_reg  <= 11'(count_reg);
                out_lg_reg     <= 4'(cur_reg);
                out_prom_reg   <= promote_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.in_valid    = in_valid;
        stat.req_type    = req_reg;
        stat.coupon_zero = coupon_reg == 32'd0;
        stat.promoted    = promote_reg;
        stat.rd_zero     = rdata == 32'd0;
        stat.rd_match    = rdata == key_reg;
        stat.probe_wrap  = p_next == first_reg;
        stat.clr_last    = clr_cnt_reg == lg_mask(clr_lg_reg);
        stat.scan_last   = scan_reg == lg_mask(cur_reg);
        stat.grow_need   = lhs > rhs;
        stat.at_limit    = 5'(cur_reg) >= limc;
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot_value    = out_slot_reg;
    assign coupon_total  = out_total_reg;
    assign table_lg_size = out_lg_reg;
    assign promoted      = out_prom_reg;

endmodule

[sv/coupon_hash_set_insert.sv]
// coupon hash set top level: controller, datapath and checks
// Request words enter on in_valid/in_stall (req_type, coupon, slot_index); one
// result word per request leaves on out_valid/out_stall. Config registers are
// written through cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. One request is worked at a time; in_stall is low only while idle.
// Both table banks sit behind one read port each; a probe sets the address,
// then compares on the registered read data.
// A grow clears the other bank, then scans every old slot and rehashes each used one.
// After reset the block clears 32 slots of bank a (one per cycle) before it
// takes a request. A finished word waits in the output register while the
// receiver stalls; the block may accept and work the next request meanwhile,
// and holds its result until the register frees.
module coupon_hash_set_insert #(
    parameter int MAX_LG_TABLE = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] coupon,
    input  logic [9:0]  slot_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] slot_value,
    output logic [10:0] coupon_total,
    output logic [3:0]  table_lg_size,
    output logic        promoted
);

    chs_pkg::cmd_t  cmd;
    chs_pkg::stat_t stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = !cmd.in_ready;

    chs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    chs_dpath #(.MAX_LG_TABLE(MAX_LG_TABLE)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .req_type      (req_type),
        .coupon        (coupon),
        .slot_index    (slot_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .slot_value    (slot_value),
        .coupon_total  (coupon_total),
        .table_lg_size (table_lg_size),
        .promoted      (promoted)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while busy");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_step && cmd.probe_write))
        else $error("clear and probe write collide");

    a_promote_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == chs_pkg::ST_PROMOTE) |-> promoted)
        else $error("promote status without flag");

endmodule

[tb/coupon_set_checker.sv]
// checker for the coupon hash set: mirrors the table and compares result words
`timescale 1ns / 1ps

module coupon_set_checker
    import chs_pkg::*;
#(
    parameter int MAX_LG_TABLE = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] coupon,
    input  logic [9:0]  slot_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [31:0] slot_value,
    input  logic [10:0] coupon_total,
    input  logic [3:0]  table_lg_size,
    input  logic        promoted,
    output int          fail_count,
    output int          pending_words,
    output int          promote_count,
    output int          grow_count
);

    localparam int DEPTH = 1 << MAX_LG_TABLE;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] slot_value;
        logic [10:0] coupon_total;
        logic [3:0]  table_lg_size;
        logic        promoted;
    } set_word_t;

    logic [31:0] bank [2][DEPTH];
    int          act_bank;
    int          lg_cur;
    int          held;
    logic        promo;
    int          lg_sketch;
    int          grow_num;
    int          grow_den;
    int          start_lg;
    set_word_t   expected_words [$];

    function automatic int clamp_start();
        return (start_lg > MAX_LG_TABLE) ? MAX_LG_TABLE : start_lg;
    endfunction

    function automatic int lg_limit();
        int lim;
        lim = (lg_sketch < 3) ? 0 : lg_sketch - 3;
        return (lim > MAX_LG_TABLE) ? MAX_LG_TABLE : lim;
    endfunction

    task automatic empty_banks();
        for (int i = 0; i < DEPTH; i++)
        begin
            bank[0][i] = '0;
            bank[1][i] = '0;
        end
        act_bank = 0;
        lg_cur   = clamp_start();
        held     = 0;
        promo    = 1'b0;
    endtask

    // 0 empty slot found, 1 already present, 2 full
    function automatic int probe_slot(int b, int lg, logic [31:0] c, output int slot);
        logic [31:0] mask;
        logic [31:0] p;
        logic [31:0] first;
        logic [31:0] stride;
        logic [31:0] v;
        mask   = (32'd1 << lg) - 1;
        p      = c & mask;
        first  = p;
        stride = ((c & 32'h3FFFFFF) >> lg) | 32'd1;
        slot   = 0;
        do
        begin
            v = bank[b][p % DEPTH];
            if (v == 0)
            begin
                slot = p;
                return 0;
            end
            if (v == c)
            begin
                slot = p;
                return 1;
            end
            p = (p + stride) & mask;
        end while (p != first);
        return 2;
    endfunction

    function automatic void double_table();
        int src;
        int dst;
        int s;
        src = act_bank;
        dst = 1 - act_bank;
        for (int i = 0; i < DEPTH; i++)
            bank[dst][i] = '0;
        for (int i = 0; i < (1 << lg_cur); i++)
            if (bank[src][i] != 0 && probe_slot(dst, lg_cur + 1, bank[src][i], s) == 0)
                bank[dst][s] = bank[src][i];
        act_bank = dst;
        lg_cur   = lg_cur + 1;
        grow_count++;
    endfunction

    function automatic logic [2:0] insert_coupon(logic [31:0] c);
        int r;
        int s;
        longint lhs;
        longint rhs;
        if (c == 0 || promo)
            return ST_IGNORED;
        r = probe_slot(act_bank, lg_cur, c, s);
        if (r == 1)
            return ST_DUP;
        if (r == 2)
            return ST_IGNORED;
        bank[act_bank][s] = c;
        held++;
        lhs = longint'(grow_den) * held;
        rhs = longint'(grow_num) * (longint'(1) << lg_cur);
        if (lhs > rhs)
        begin
            if (lg_cur >= lg_limit())
            begin
                promo = 1'b1;
                promote_count++;
                return ST_PROMOTE;
            end
            double_table();
        end
        return ST_INSERTED;
    endfunction

    task automatic predict_word(logic [1:0] rt, logic [31:0] c, logic [9:0] idx);
        set_word_t w;
        w = '0;
        w.status = ST_IGNORED;
        if (rt == REQ_INSERT)
            w.status = insert_coupon(c);
        else if (rt == REQ_READ)
        begin
            w.status = ST_SLOT;
            if (idx < (1 << lg_cur))
                w.slot_value = bank[act_bank][idx];
        end
        else if (rt == REQ_CLEAR)
        begin
            w.status = ST_SLOT;
            empty_banks();
        end
        w.coupon_total  = held[10:0];
        w.table_lg_size = lg_cur[3:0];
        w.promoted      = promo;
        expected_words.push_back(w);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic compare_word();
        set_word_t e;
        if (expected_words.size() == 0)
        begin
            report_mismatch("unexpected word", status, 0);
            return;
        end
        e = expected_words.pop_front();
        if (status !== e.status)
            report_mismatch("status", status, e.status);
        if (slot_value !== e.slot_value)
            report_mismatch("slot_value", slot_value, e.slot_value);
        if (coupon_total !== e.coupon_total)
            report_mismatch("coupon_total", coupon_total, e.coupon_total);
        if (table_lg_size !== e.table_lg_size)
            report_mismatch("table_lg_size", table_lg_size, e.table_lg_size);
        if (promoted !== e.promoted)
            report_mismatch("promoted", promoted, e.promoted);
    endtask

    initial
    begin
        fail_count    = 0;
        pending_words = 0;
        promote_count = 0;
        grow_count    = 0;
        lg_sketch     = LG_SKETCH_RST;
        grow_num      = GROW_NUM_RST;
        grow_den      = GROW_DEN_RST;
        start_lg      = START_LG_RST;
        empty_banks();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                compare_word();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LG_SKETCH: lg_sketch = cfg_data;
                    CFG_GROW_NUM:  grow_num  = cfg_data[3:0];
                    CFG_GROW_DEN:  grow_den  = cfg_data[3:0];
                    CFG_START_LG:  start_lg  = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_word(req_type, coupon, slot_index);
        end
        pending_words = expected_words.size();
    end

endmodule

[tb/tb_coupon_hash_set_insert.sv]
// testbench top for the coupon hash set: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_coupon_hash_set_insert;
    import chs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [31:0] coupon;
    logic [9:0]  slot_index;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [31:0] slot_value;
    logic [10:0] coupon_total;
    logic [3:0]  table_lg_size;
    logic        promoted;
    int          fail_count;
    int          pending_words;
    int          promote_count;
    int          grow_count;
    int          cycle_count;
    int          words_sent;
    logic        calm_mode;
    logic        hold_off;
    logic [31:0] recent [$];

    localparam int CYCLE_LIMIT = 4000000;

    coupon_hash_set_insert i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .coupon(coupon), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot_value(slot_value), .coupon_total(coupon_total),
        .table_lg_size(table_lg_size), .promoted(promoted)
    );

    coupon_set_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .coupon(coupon), .slot_index(slot_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .slot_value(slot_value), .coupon_total(coupon_total),
        .table_lg_size(table_lg_size), .promoted(promoted),
        .fail_count(fail_count), .pending_words(pending_words),
        .promote_count(promote_count), .grow_count(grow_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("coupon_hash_set_insert test failed");
            $finish;
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (calm_mode)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 18);
    end

    task automatic send_word(logic [1:0] rt, logic [31:0] c, logic [9:0] idx);
        if (!calm_mode)
            while ($urandom_range(99) < 18)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid   <= 1'b1;
        req_type   <= rt;
        coupon     <= c;
        slot_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        recent.push_back(c);
        if (recent.size() > 64)
            void'(recent.pop_front());
    endtask

    task automatic drain_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(int lgk, int gn, int gd, int slg);
        drain_quiet();
        write_reg(CFG_LG_SKETCH, lgk[4:0]);
        write_reg(CFG_GROW_NUM, gn[4:0]);
        write_reg(CFG_GROW_DEN, gd[4:0]);
        write_reg(CFG_START_LG, slg[4:0]);
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coupon();
        int r;
        r = $urandom_range(99);
        if (r < 12 && recent.size() > 0)
            return recent[$urandom_range(recent.size() - 1)];
        if (r < 15)
            return 32'd0;
        return $urandom;
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 80)
                send_word(REQ_INSERT, pick_coupon(), 10'($urandom));
            else if (r < 95)
                send_word(REQ_READ, $urandom, 10'($urandom_range(1023)));
            else if (r < 98)
                send_word(REQ_CLEAR, $urandom, 10'($urandom));
            else
                send_word(2'd3, $urandom, 10'($urandom));
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        cycle_count = 0;
        words_sent  = 0;
        calm_mode   = 1'b0;
        hold_off    = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LG_SKETCH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = REQ_INSERT;
        coupon      = '0;
        slot_index  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicates, reads, clear, unknown type
        send_word(REQ_INSERT, 32'd0, 10'd0);
        send_word(REQ_INSERT, 32'hFFFFFFFF, 10'h3FF);
        send_word(REQ_INSERT, 32'hFFFFFFFF, 10'd0);
        send_word(REQ_INSERT, 32'h00000001, 10'd0);
        send_word(REQ_INSERT, 32'h00000021, 10'd0);
        send_word(REQ_INSERT, 32'hAAAAAAAA, 10'd0);
        send_word(REQ_INSERT, 32'h55555555, 10'd0);
        send_word(REQ_READ, 32'd0, 10'd1);
        send_word(REQ_READ, 32'hFFFFFFFF, 10'd31);
        send_word(REQ_READ, 32'd0, 10'h3FF);
        send_word(2'd3, 32'h12345678, 10'h155);
        send_word(REQ_CLEAR, 32'd0, 10'h2AA);
        send_word(REQ_READ, 32'd0, 10'd31);

        // full table: smallest size, never grows, no promotion
        set_regs(21, 15, 1, 2);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        for (int i = 1; i <= 6; i++)
            send_word(REQ_INSERT, i * 32'h01010101, 10'd0);
        for (int i = 0; i < 4; i++)
            send_word(REQ_READ, 32'd0, 10'(i));

        // limit below zero: lg_sketch 0, would promote at first grow; too few requests to reach it
        set_regs(0, 1, 15, 15);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        random_phase(60);

        // long stall so the output backs up
        set_regs(13, 3, 4, 5);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(40);
        join

        calm_mode = 1'b1;
        random_phase(200);
        calm_mode = 1'b0;

        set_regs(8, 1, 15, 2);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        random_phase(300);
        set_regs(21, 15, 1, 10);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        random_phase(300);
        set_regs(11, 3, 4, 3);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        random_phase(400);
        set_regs(13, 7, 8, 4);
        send_word(REQ_CLEAR, 32'd0, 10'd0);
        random_phase(450);

        drain_quiet();
        $display("sent %0d request words over several register settings", words_sent);
        $display("saw %0d table doublings and %0d promotions", grow_count, promote_count);
        if (fail_count == 0)
            $display("coupon_hash_set_insert test passed");
        else
            $display("coupon_hash_set_insert test failed");
        $finish;
    end

endmodule
